### hw/rtl/pbgd_pkg.sv
// ---------------------------------------------------------------------------
// pbgd_pkg
// Shared widths, constants and controller/datapath interface types for the
// price bar gap detector.
// ---------------------------------------------------------------------------
package pbgd_pkg;

	// field widths fixed by the bar format
	localparam int unsigned PRICE_W   = 32;
	localparam int unsigned TIME_W    = 64;
	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned MIN_GAP_W = 31;

	// divider operands: numerator is diff * 100, denominator a price
	localparam int unsigned PCT_SCALE_W = 7;
	localparam int unsigned NUM_W       = PRICE_W + PCT_SCALE_W;
	localparam int unsigned DEN_W       = PRICE_W;
	localparam int unsigned Q_W         = 32;

	localparam logic [PCT_SCALE_W-1:0] PCT_SCALE = 7'd100;

	// saturation limits
	localparam logic [Q_W-1:0] PCT_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [Q_W-1:0] PCT_NEG_MAX = 32'h8000_0000;
	localparam logic [Q_W-1:0] RATIO_MAX   = 32'hFFFF_FFFF;

	// configuration register indexes
	localparam int unsigned CFG_ADDR_W = 2;
	localparam logic [CFG_ADDR_W-1:0] REG_MIN_GAP  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_FILL_THR = 2'd1;

	localparam logic [MIN_GAP_W-1:0] MIN_GAP_RESET  = '0;
	localparam logic [PRICE_W-1:0]   FILL_THR_RESET = 32'd65536;

	// controller to datapath
	typedef struct packed {
		logic load;         // capture the accepted bar, roll prior state
		logic mul;          // form diff * 100
		logic div_start;    // launch the shared divider
		logic div_ratio;    // divider operands: retrace ratio, else percent
		logic pct_latch;    // keep saturated percent magnitude
		logic ratio_latch;  // keep saturated retrace ratio
		logic ratio_clear;  // retrace ratio is zero
		logic out_load;     // fill the output register
	} pbgd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic elig;      // open and prior close valid and different
		logic qualify;   // percent magnitude reaches threshold
		logic rgo;       // range valid and prior close touched
		logic div_busy;
		logic div_done;
	} pbgd_status_t;

endpackage

### hw/rtl/pbgd_div.sv
// ---------------------------------------------------------------------------
// pbgd_div
// Radix-2 restoring divider: floor(num * 2^16 / den) with
// overflow detected up front and flagged on sat, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module pbgd_div
	import pbgd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic             sat,
	output logic [Q_W-1:0]   quot
);

	localparam int unsigned CNT_W = $clog2(Q_W);
	localparam int unsigned CMP_W = DEN_W + FRAC_BITS;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic             sat_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [Q_W-1:0]   nb_q;
	logic [Q_W-1:0]   q_q;

	logic             ovf;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   trial_sub;
	logic             ge;

	// quotient overflows 32 bits exactly when num >= den * 2^16
	always_comb begin
		ovf = CMP_W'(num) >= {den, {FRAC_BITS{1'b0}}};
	end

	// one restoring step
	always_comb begin
		trial     = {rem_q, nb_q[Q_W-1]};
		ge        = trial >= {1'b0, den_q};
		trial_sub = trial - {1'b0, den_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= !ovf;
				done_q <= ovf;
				cnt_q  <= CNT_W'(Q_W - 1);
			end else if (busy_q) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == '0);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			sat_q <= ovf;
			den_q <= den;
			rem_q <= DEN_W'(num[NUM_W-1:FRAC_BITS]);
			nb_q  <= {num[FRAC_BITS-1:0], {(Q_W-FRAC_BITS){1'b0}}};
			q_q   <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
			nb_q  <= {nb_q[Q_W-2:0], 1'b0};
			q_q   <= {q_q[Q_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign sat  = sat_q;
	assign quot = q_q;

	// a start never lands on a division in progress
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");

	// a non-overflow start runs the iteration
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !ovf) |=> (busy_q && !done_q))
		else $error("divider did not begin iterating");

	// done never while the iteration runs
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while busy");

endmodule

### hw/rtl/pbgd_datapath.sv
// ---------------------------------------------------------------------------
// pbgd_datapath
// Prior bar state, configuration registers, gap operands, shared divider,
// saturation and the output register.
// ---------------------------------------------------------------------------
module pbgd_datapath
	import pbgd_pkg::*;
#(
	parameter int unsigned PRICE_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pbgd_cmd_t                cmd,
	output pbgd_status_t             status,
	// configuration
	input  logic                     cfg_we,
	input  logic [CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [PRICE_W-1:0]       cfg_wdata,
	// input bar
	input  logic [PRICE_W-1:0]       in_open,
	input  logic                     in_open_valid,
	input  logic [PRICE_W-1:0]       in_high,
	input  logic [PRICE_W-1:0]       in_low,
	input  logic                     in_range_valid,
	input  logic [PRICE_W-1:0]       in_close,
	input  logic                     in_close_valid,
	input  logic signed [TIME_W-1:0] in_time,
	// result
	output logic                     out_found,
	output logic                     out_filled,
	output logic [Q_W-1:0]           out_ratio,
	output logic signed [Q_W-1:0]    out_pct,
	output logic [PRICE_W-1:0]       out_prior_close,
	output logic signed [TIME_W-1:0] out_prior_time
);

	localparam logic [PRICE_W-1:0] PRICE_MASK = (PRICE_WIDTH >= PRICE_W) ? '1 :
		PRICE_W'((64'd1 << PRICE_WIDTH) - 64'd1);

	// configuration
	logic [MIN_GAP_W-1:0] min_gap_q;
	logic [PRICE_W-1:0]   fill_thr_q;

	// prior bar
	logic [PRICE_W-1:0]       last_close_q;
	logic                     last_pres_q;
	logic signed [TIME_W-1:0] last_time_q;

	// working set of the current bar
	logic [PRICE_W-1:0]       pc_q;
	logic signed [TIME_W-1:0] pt_q;
	logic                     up_q;
	logic                     elig_q;
	logic                     rv_q;
	logic                     rgo_q;
	logic [PRICE_W-1:0]       diff_q;
	logic [PRICE_W-1:0]       rnum_q;
	logic [NUM_W-1:0]         num_q;
	logic [Q_W-1:0]           mag_q;
	logic [Q_W-1:0]           ratio_q;

	// output register
	logic                     found_q;
	logic                     filled_q;
	logic [Q_W-1:0]           oratio_q;
	logic [Q_W-1:0]           opct_q;
	logic [PRICE_W-1:0]       opc_q;
	logic signed [TIME_W-1:0] opt_q;

	logic [PRICE_W-1:0] o_m;
	logic [PRICE_W-1:0] h_m;
	logic [PRICE_W-1:0] l_m;
	logic [PRICE_W-1:0] c_m;
	logic               up_d;
	logic               touch_d;

	logic [NUM_W-1:0]   div_num;
	logic [DEN_W-1:0]   div_den;
	logic [Q_W-1:0]     div_limit;
	logic               div_busy;
	logic               div_done;
	logic               div_sat;
	logic [Q_W-1:0]     div_q;
	logic [Q_W-1:0]     div_res;
	logic               qualify;
	logic               found_d;

	// masked prices and gap direction against the stored close
	always_comb begin
		o_m     = in_open  & PRICE_MASK;
		h_m     = in_high  & PRICE_MASK;
		l_m     = in_low   & PRICE_MASK;
		c_m     = in_close & PRICE_MASK;
		up_d    = o_m > last_close_q;
		touch_d = up_d ? (l_m <= last_close_q) : (h_m >= last_close_q);
	end

	// configuration writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q  <= MIN_GAP_RESET;
			fill_thr_q <= FILL_THR_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MIN_GAP:  min_gap_q  <= cfg_wdata[MIN_GAP_W-1:0];
				REG_FILL_THR: fill_thr_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// prior bar state rolls on every accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_close_q <= '0;
			last_pres_q  <= 1'b0;
			last_time_q  <= '0;
		end else if (cmd.load) begin
			last_close_q <= c_m;
			last_pres_q  <= in_close_valid;
			last_time_q  <= in_time;
		end
	end

	// capture operands of the current bar
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pc_q   <= last_close_q;
			pt_q   <= last_time_q;
			up_q   <= up_d;
			elig_q <= in_open_valid && last_pres_q && (o_m != last_close_q);
			rv_q   <= in_range_valid;
			rgo_q  <= in_range_valid && touch_d;
			diff_q <= up_d ? (o_m - last_close_q) : (last_close_q - o_m);
			rnum_q <= up_d ? (o_m - l_m) : (h_m - o_m);
		end
		if (cmd.mul) begin
			num_q <= NUM_W'(diff_q) * NUM_W'(PCT_SCALE);
		end
		if (cmd.pct_latch) begin
			mag_q <= div_res;
		end
		if (cmd.ratio_latch) begin
			ratio_q <= div_res;
		end else if (cmd.ratio_clear) begin
			ratio_q <= '0;
		end
	end

	// divider operand select
	always_comb begin
		if (cmd.div_ratio) begin
			div_num   = NUM_W'(rnum_q);
			div_den   = diff_q;
			div_limit = RATIO_MAX;
		end else begin
			div_num   = num_q;
			div_den   = pc_q;
			div_limit = up_q ? PCT_POS_MAX : PCT_NEG_MAX;
		end
	end

	pbgd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.sat    (div_sat),
		.quot   (div_q)
	);

	// saturate the quotient
	always_comb begin
		if (div_sat || (div_q > div_limit)) begin
			div_res = div_limit;
		end else begin
			div_res = div_q;
		end
		qualify = mag_q >= Q_W'(min_gap_q);
		found_d = elig_q && qualify;
	end

	// output register, all zero when no gap
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			found_q  <= found_d;
			filled_q <= found_d && rv_q && (ratio_q >= fill_thr_q);
			oratio_q <= found_d ? ratio_q : '0;
			opct_q   <= found_d ? (up_q ? mag_q : (Q_W'(0) - mag_q)) : '0;
			opc_q    <= found_d ? pc_q : '0;
			opt_q    <= found_d ? pt_q : '0;
		end
	end

	always_comb begin
		status.elig     = elig_q;
		status.qualify  = qualify;
		status.rgo      = rgo_q;
		status.div_busy = div_busy;
		status.div_done = div_done;
	end

	assign out_found       = found_q;
	assign out_filled      = filled_q;
	assign out_ratio       = oratio_q;
	assign out_pct         = opct_q;
	assign out_prior_close = opc_q;
	assign out_prior_time  = opt_q;

endmodule

### hw/rtl/pbgd_ctrl.sv
// ---------------------------------------------------------------------------
// pbgd_ctrl
// Sequencer for one bar: operand capture, percent division, threshold
// check, retrace division and hand-off to the output register.
// ---------------------------------------------------------------------------
module pbgd_ctrl
	import pbgd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  pbgd_status_t status,
	output pbgd_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_PCT_GO,
		ST_PCT_WAIT,
		ST_PCT_CHK,
		ST_RAT_WAIT,
		ST_FIN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   in_acc;
	logic   out_free;

	always_comb begin
		in_acc   = (state_q == ST_IDLE) && in_valid;
		out_free = !out_valid_q || out_ready;
	end

	// command decode and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.elig) begin
					cmd.mul = 1'b1;
					state_d = ST_PCT_GO;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_PCT_GO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_PCT_WAIT;
			end
			ST_PCT_WAIT: begin
				if (status.div_done) begin
					cmd.pct_latch = 1'b1;
					state_d       = ST_PCT_CHK;
				end
			end
			ST_PCT_CHK: begin
				if (status.qualify && status.rgo) begin
					cmd.div_start = 1'b1;
					cmd.div_ratio = 1'b1;
					state_d       = ST_RAT_WAIT;
				end else begin
					cmd.ratio_clear = 1'b1;
					state_d         = ST_FIN;
				end
			end
			ST_RAT_WAIT: begin
				cmd.div_ratio = 1'b1;
				if (status.div_done) begin
					cmd.ratio_latch = 1'b1;
					state_d         = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// one bar at a time: no second beat right after an accept
	a_one_bar: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input accepted while bar in progress");

	// output register never overwritten while a result waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("result overwritten before taken");

	// divider launched only when free
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !status.div_busy)
		else $error("divider launched while busy");

endmodule

### hw/rtl/price_bar_gap_detector_core.sv
// ---------------------------------------------------------------------------
// price_bar_gap_detector_core
// Opening gap detector for a stream of price bars.
// ---------------------------------------------------------------------------
// One bar enters per s_axis beat; each bar yields exactly one m_axis beat,
// either a gap report or an all-zero no-gap result. The bar's close and time
// become the prior bar for the next beat, whatever the outcome.
// A bar with no usable gap goes from operand capture and the check straight
// to the output register; otherwise the percent is divided, and the retrace
// ratio is divided too when the percent reaches the threshold and the range
// touches the prior close. Both divisions share one radix-2 divider that
// retires one quotient bit per cycle; a division that overflows saturates
// without iterating. The next bar waits until this sequence is complete.
// s_axis_tready is high only while no bar is in progress. The result sits
// in an output register, so the next bar is accepted while a result waits;
// if m_axis_tready stays low the finished second bar holds until the first
// is taken. Reset clears the prior close flag (so the first bar reports no
// gap), the prior close and time, and loads the configuration reset values.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata by the user
// only while idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module price_bar_gap_detector_core
	import pbgd_pkg::*;
#(
	parameter int unsigned PRICE_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [PRICE_W-1:0]    cfg_wdata,
	// bar input
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// open_price, high_price, low_price, close_price, bar_time
	input  logic [191:0]          s_axis_tdata,
	// open_valid, range_valid, close_valid
	input  logic [2:0]            s_axis_tuser,
	// result output
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// retrace_ratio, gap_percent, prior_close, prior_time
	output logic [159:0]          m_axis_tdata,
	// gap_found, fill flag
	output logic [1:0]            m_axis_tuser
);

	pbgd_cmd_t    cmd;
	pbgd_status_t status;

	logic                     found;
	logic                     filled;
	logic [Q_W-1:0]           ratio;
	logic signed [Q_W-1:0]    pct;
	logic [PRICE_W-1:0]       prior_close;
	logic signed [TIME_W-1:0] prior_time;

	pbgd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.status    (status),
		.cmd       (cmd)
	);

	pbgd_datapath #(
		.PRICE_WIDTH (PRICE_WIDTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg_we),
		.cfg_addr        (cfg_addr),
		.cfg_wdata       (cfg_wdata),
		.in_open         (s_axis_tdata[31:0]),
		.in_open_valid   (s_axis_tuser[0]),
		.in_high         (s_axis_tdata[63:32]),
		.in_low          (s_axis_tdata[95:64]),
		.in_range_valid  (s_axis_tuser[1]),
		.in_close        (s_axis_tdata[127:96]),
		.in_close_valid  (s_axis_tuser[2]),
		.in_time         (s_axis_tdata[191:128]),
		.out_found       (found),
		.out_filled      (filled),
		.out_ratio       (ratio),
		.out_pct         (pct),
		.out_prior_close (prior_close),
		.out_prior_time  (prior_time)
	);

	// pack the result beat
	assign m_axis_tdata = {prior_time, prior_close, pct, ratio};
	assign m_axis_tuser = {filled, found};

endmodule

### sim/price_bar_gap_detector_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// price_bar_gap_detector_core_tb
// Self-checking bench for the opening gap detector on price bar streams.
// ---------------------------------------------------------------------------
// Bars are queued by the stimulus process and driven by a clocked driver with
// random gaps. Each accepted bar runs through an in-bench gap predictor that
// keeps its own prior close, prior time and register copies. The expected
// report is queued, and a clocked monitor compares every result beat field
// by field. A directed set covers first bar, invalid prices, equal open,
// zero and extreme prior closes, saturation and untouched gaps. Random
// phases under varied thresholds follow, one of them with a long output
// stall that backs the block up.
// ---------------------------------------------------------------------------
module price_bar_gap_detector_core_tb;
	import pbgd_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 600000;
	localparam int unsigned PHASES        = 8;
	localparam int unsigned BARS_PER_PHASE = 105;
	localparam int unsigned HOLDOFF_CYCLES = 300;
	localparam int unsigned MAX_REPORTS   = 10;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 2'd3;

	// one bar, laid out as {tuser, tdata}
	typedef struct packed {
		logic                close_ok;
		logic                range_ok;
		logic                open_ok;
		logic [TIME_W-1:0]   stamp;
		logic [PRICE_W-1:0]  close_px;
		logic [PRICE_W-1:0]  low_px;
		logic [PRICE_W-1:0]  high_px;
		logic [PRICE_W-1:0]  open_px;
	} bar_t;

	// one gap report, laid out as {tuser, tdata}
	typedef struct packed {
		logic                filled;
		logic                found;
		logic [TIME_W-1:0]   prior_time;
		logic [PRICE_W-1:0]  prior_close;
		logic [Q_W-1:0]      pct;
		logic [Q_W-1:0]      ratio;
	} gap_report_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [PRICE_W-1:0]    cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [191:0]          s_axis_tdata = '0;  // open, high, low, close, bar_time
	logic [2:0]            s_axis_tuser = '0;  // open_valid, range_valid, close_valid
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [159:0]          m_axis_tdata;       // ratio, percent, prior close, prior time
	logic [1:0]            m_axis_tuser;       // gap_found, fill flag

	// predictor state and register copies
	logic [PRICE_W-1:0]   prior_close = '0;
	logic                 prior_ok = 1'b0;
	logic [TIME_W-1:0]    prior_stamp = '0;
	logic [MIN_GAP_W-1:0] gap_floor = MIN_GAP_RESET;
	logic [PRICE_W-1:0]   fill_floor = FILL_THR_RESET;

	bar_t        bars_to_send[$];
	gap_report_t pending_reports[$];

	logic s_fire = 1'b0;
	logic m_fire = 1'b0;
	bit   tx_calm = 1'b0;
	bit   rx_calm = 1'b0;
	bit   rx_hold = 1'b0;
	bit   holdoff_go = 1'b0;
	int unsigned tx_wait = 0;
	int unsigned rx_wait = 0;

	int unsigned cycle_count = 0;
	int unsigned mismatches = 0;
	int unsigned bars_in = 0;
	int unsigned reports_out = 0;
	int unsigned gaps_seen = 0;
	int unsigned fills_seen = 0;
	int unsigned reg_writes = 0;

	logic [PRICE_W-1:0] gen_close = '0;
	logic [TIME_W-1:0]  gen_stamp = '0;

	price_bar_gap_detector_core #(
		.PRICE_WIDTH(PRICE_W)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #6 clk = ~clk;

	// floor(num * 2^16 / den) clipped at limit; zero divisor gives the limit
	function automatic logic [63:0] q16_quot_sat(input logic [63:0] num,
			input logic [63:0] den, input logic [63:0] limit);
		logic [63:0] q;
		if (den == 0)
			return limit;
		q = (num << FRAC_BITS) / den;
		return (q > limit) ? limit : q;
	endfunction

	// expected report for one bar against the current prior bar
	function automatic gap_report_t predict_gap(input bar_t b);
		gap_report_t r;
		logic        up;
		logic [63:0] diff;
		logic [63:0] mag;
		logic [63:0] ratio;
		r = '0;
		if (b.open_ok && prior_ok && b.open_px != prior_close) begin
			up = b.open_px > prior_close;
			diff = up ? 64'(b.open_px) - 64'(prior_close) : 64'(prior_close) - 64'(b.open_px);
			mag = q16_quot_sat(diff * PCT_SCALE, 64'(prior_close),
				up ? 64'(PCT_POS_MAX) : 64'(PCT_NEG_MAX));
			if (mag >= 64'(gap_floor)) begin
				ratio = '0;
				if (b.range_ok) begin
					// retrace only counts once the prior close was touched
					if (up && b.low_px <= prior_close)
						ratio = q16_quot_sat(64'(b.open_px) - 64'(b.low_px), diff, 64'(RATIO_MAX));
					else if (!up && b.high_px >= prior_close)
						ratio = q16_quot_sat(64'(b.high_px) - 64'(b.open_px), diff, 64'(RATIO_MAX));
					r.filled = ratio >= 64'(fill_floor);
				end
				r.found = 1'b1;
				r.ratio = ratio[Q_W-1:0];
				r.pct = up ? mag[Q_W-1:0] : 32'd0 - mag[Q_W-1:0];
				r.prior_close = prior_close;
				r.prior_time = prior_stamp;
			end
		end
		return r;
	endfunction

	function automatic logic [PRICE_W-1:0] to_q16(input int unsigned whole);
		return PRICE_W'(whole) << FRAC_BITS;
	endfunction

	// extreme or random price for noise bars
	function automatic logic [PRICE_W-1:0] any_px();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 32'd1;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_bar(input logic [PRICE_W-1:0] open_px, input logic open_ok,
			input logic [PRICE_W-1:0] high_px, input logic [PRICE_W-1:0] low_px,
			input logic range_ok, input logic [PRICE_W-1:0] close_px,
			input logic close_ok, input logic [TIME_W-1:0] stamp);
		bar_t b;
		b = '{close_ok: close_ok, range_ok: range_ok, open_ok: open_ok, stamp: stamp,
			close_px: close_px, low_px: low_px, high_px: high_px, open_px: open_px};
		bars_to_send.push_back(b);
		gen_close = close_px;
		gen_stamp = stamp;
	endtask

	// mostly plausible bars near the last close, some pure noise
	task automatic push_random_bar();
		bar_t               b;
		logic [PRICE_W-1:0] base_px;
		logic [PRICE_W-1:0] delta;
		logic [PRICE_W-1:0] swing;
		if ($urandom_range(0, 6) == 0) begin
			b.open_px = any_px();
			b.high_px = any_px();
			b.low_px = any_px();
			b.close_px = any_px();
			{b.close_ok, b.range_ok, b.open_ok} = 3'($urandom_range(0, 7));
			b.stamp = {$urandom, $urandom};
		end else begin
			base_px = gen_close;
			if (base_px < 32'h0001_0000 || base_px > 32'h2000_0000)
				base_px = to_q16($urandom_range(1, 4000)) | 32'($urandom_range(0, 16'hFFFF));
			delta = ($urandom_range(0, 9) == 0) ? '0 :
				$urandom % ((base_px >> $urandom_range(2, 9)) + 1);
			b.open_px = $urandom_range(0, 1) ? base_px + delta : base_px - delta;
			swing = 2 * delta + (base_px >> 8) + 1;
			b.low_px = b.open_px - ($urandom % swing);
			b.high_px = b.open_px + ($urandom % swing);
			b.close_px = b.open_px - (swing >> 1) + ($urandom % swing);
			b.open_ok = $urandom_range(0, 15) != 0;
			b.range_ok = $urandom_range(0, 15) != 0;
			b.close_ok = $urandom_range(0, 15) != 0;
			b.stamp = gen_stamp + 64'($urandom_range(1, 1000000));
		end
		bars_to_send.push_back(b);
		gen_close = b.close_px;
		gen_stamp = b.stamp;
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [PRICE_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (addr == REG_MIN_GAP)
			gap_floor = data[MIN_GAP_W-1:0];
		else if (addr == REG_FILL_THR)
			fill_floor = data;
		reg_writes++;
	endtask

	// wait until every queued bar has been reported, then let the block settle
	task automatic drain();
		do
			@(negedge clk);
		while (bars_to_send.size() != 0 || s_axis_tvalid || pending_reports.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	// bar driver: one gap draw per bar, with calm stretches of back-to-back beats
	always @(negedge clk) begin
		if (!s_axis_tvalid || s_fire) begin
			if (tx_wait > 0) begin
				tx_wait <= tx_wait - 1;
				s_axis_tvalid <= 1'b0;
			end else if (bars_to_send.size() > 0) begin
				{s_axis_tuser, s_axis_tdata} <= bars_to_send.pop_front();
				s_axis_tvalid <= 1'b1;
				tx_wait <= tx_calm ? 0 : $urandom_range(0, 3);
				if ($urandom_range(0, 31) == 0)
					tx_calm <= !tx_calm;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result receiver: random stall after each beat, forced off during hold-off
	always @(negedge clk) begin : rx_drive
		int unsigned pause;
		if (rx_hold) begin
			m_axis_tready <= 1'b0;
		end else if (m_fire) begin
			pause = rx_calm ? 0 : $urandom_range(0, 3);
			if ($urandom_range(0, 31) == 0)
				rx_calm <= !rx_calm;
			rx_wait <= pause;
			m_axis_tready <= (pause == 0);
		end else if (rx_wait > 0) begin
			rx_wait <= rx_wait - 1;
			m_axis_tready <= (rx_wait == 1);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// long output stall while bars keep coming
	initial begin : rx_holdoff
		wait (holdoff_go);
		@(negedge clk);
		rx_hold <= 1'b1;
		repeat (HOLDOFF_CYCLES) @(negedge clk);
		rx_hold <= 1'b0;
	end

	// monitor: predict on accepted bars, check result beats in order
	always @(posedge clk) begin : monitor
		bar_t        arrived;
		gap_report_t seen;
		gap_report_t want;
		cycle_count++;
		s_fire <= s_axis_tvalid && s_axis_tready;
		m_fire <= m_axis_tvalid && m_axis_tready;
		if (s_axis_tvalid && s_axis_tready) begin
			arrived = bar_t'({s_axis_tuser, s_axis_tdata});
			pending_reports.push_back(predict_gap(arrived));
			prior_close = arrived.close_px;
			prior_ok = arrived.close_ok;
			prior_stamp = arrived.stamp;
			bars_in++;
		end
		if (m_axis_tvalid && m_axis_tready) begin
			seen = gap_report_t'({m_axis_tuser, m_axis_tdata});
			reports_out++;
			gaps_seen += seen.found;
			fills_seen += seen.filled;
			if (pending_reports.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("%0t: result beat with no bar outstanding", $realtime);
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				if (seen.found !== want.found || seen.filled !== want.filled ||
						seen.ratio !== want.ratio || seen.pct !== want.pct ||
						seen.prior_close !== want.prior_close ||
						seen.prior_time !== want.prior_time) begin
					if (mismatches < MAX_REPORTS)
						$display({"%0t: result %0d exp/act found %b/%b filled %b/%b ",
							"ratio %h/%h pct %h/%h close %h/%h time %h/%h"},
							$realtime, reports_out, want.found, seen.found,
							want.filled, seen.filled, want.ratio, seen.ratio,
							want.pct, seen.pct, want.prior_close, seen.prior_close,
							want.prior_time, seen.prior_time);
					mismatches++;
				end
			end
		end
	end

	// cycle limit
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT)
			@(negedge clk);
		$display("timeout after %0d cycles, %0d bars in, %0d results out",
			cycle_count, bars_in, reports_out);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		int unsigned        phase;
		logic [PRICE_W-1:0] floor_cfg;
		logic [PRICE_W-1:0] thr_cfg;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed bars under reset thresholds (no floor, fill at 1.0)
		@(posedge clk);
		// first bar after reset has no prior
		push_bar(to_q16(100), 1, to_q16(101), to_q16(99), 1, to_q16(100), 1, 64'd0);
		// up gap of 10 percent, retrace past prior close
		push_bar(to_q16(110), 1, to_q16(112), to_q16(99), 1, to_q16(100), 1,
			64'h7FFF_FFFF_FFFF_FFFF);
		// down gap of 10 percent, retrace past prior close
		push_bar(to_q16(90), 1, to_q16(101), to_q16(88), 1, to_q16(100), 1,
			64'h8000_0000_0000_0000);
		// open equal to prior close
		push_bar(to_q16(100), 1, to_q16(101), to_q16(99), 1, to_q16(100), 1, '1);
		// open missing
		push_bar(to_q16(130), 0, to_q16(131), to_q16(99), 1, to_q16(100), 1, 64'd5);
		// untouched up gap, close missing for the next bar
		push_bar(to_q16(105), 1, to_q16(106), to_q16(104), 1, to_q16(50), 0, 64'd6);
		// prior close absent
		push_bar(to_q16(120), 1, to_q16(121), to_q16(119), 1, '0, 1, 64'd7);
		// prior close zero saturates the percent
		push_bar(to_q16(5), 1, to_q16(6), '0, 1, '1, 1, 64'd8);
		// open zero below the top price, range missing
		push_bar('0, 1, '1, '0, 0, 32'd1, 1, 64'd9);
		// top price over the smallest prior close
		push_bar('1, 1, '1, '0, 1, to_q16(100), 1, 64'd10);
		// one-lsb gap, ratio saturates
		push_bar(to_q16(100) + 1, 1, to_q16(101), '0, 1, to_q16(100), 1, 64'd11);
		// untouched down gap
		push_bar(to_q16(90), 1, to_q16(95), to_q16(89), 1, to_q16(100), 1, 64'd12);
		// down gap retraced exactly to prior close
		push_bar(to_q16(80), 1, to_q16(100), to_q16(79), 1, to_q16(100), 1, 64'd13);
		drain();

		// highest floor, zero fill threshold, spare indexes ignored
		write_reg(REG_MIN_GAP, '1);
		write_reg(REG_FILL_THR, '0);
		write_reg(REG_SPARE_LO, 32'h0000_5555);
		write_reg(REG_SPARE_HI, 32'hAAAA_0000);
		@(posedge clk);
		push_bar(to_q16(110), 1, to_q16(111), to_q16(109), 1, '0, 1, 64'd14);
		push_bar(to_q16(7), 1, to_q16(9), to_q16(3), 1, '1, 1, 64'd15);
		push_bar('0, 1, to_q16(1), '0, 0, to_q16(200), 1, 64'd16);
		drain();

		// five percent floor, top fill threshold
		write_reg(REG_MIN_GAP, to_q16(5));
		write_reg(REG_FILL_THR, '1);
		@(posedge clk);
		push_bar(to_q16(204), 1, to_q16(205), to_q16(199), 1, to_q16(200), 1, 64'd17);
		push_bar(to_q16(220), 1, to_q16(221), '0, 1, to_q16(200), 1, 64'd18);
		push_bar(to_q16(210), 1, to_q16(211), '0, 1, to_q16(200), 1, 64'd19);
		drain();

		// random phases under varied thresholds
		for (phase = 0; phase < PHASES; phase++) begin
			case ($urandom_range(0, 5))
				0, 1: floor_cfg = '0;
				2, 3: floor_cfg = $urandom_range(0, to_q16(12));
				4: floor_cfg = $urandom;
				default: floor_cfg = 32'h7FFF_FFFF;
			endcase
			case ($urandom_range(0, 4))
				0: thr_cfg = '0;
				1: thr_cfg = to_q16(1);
				2: thr_cfg = $urandom_range(to_q16(1) >> 1, to_q16(2));
				3: thr_cfg = $urandom;
				default: thr_cfg = '1;
			endcase
			write_reg(REG_MIN_GAP, floor_cfg);
			write_reg(REG_FILL_THR, thr_cfg);
			@(posedge clk);
			repeat (BARS_PER_PHASE) push_random_bar();
			if (phase == 1)
				holdoff_go = 1'b1;
			drain();
		end

		repeat (80) @(negedge clk);
		if (pending_reports.size() != 0) begin
			$display("%0d expected results never arrived", pending_reports.size());
			mismatches += pending_reports.size();
		end

		$display("run covered %0d bars and %0d results: %0d gaps, %0d filled",
			bars_in, reports_out, gaps_seen, fills_seen);
		$display("%0d register writes over %0d random phases, one %0d-cycle output stall",
			reg_writes, PHASES, HOLDOFF_CYCLES);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
